/* hw/rtl/zdsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package zdsc_pkg;

  localparam int MAX_DIM_DEF = 256;
  localparam int PIX_W       = 8;
  localparam int DIM_IN_W    = 9;
  localparam int SUIT_W      = 3;
  localparam int ZONE_W      = 4;
  localparam int ZONES       = 16;
  localparam int ADDR_W      = ZONE_W + 1;
  localparam int READS       = 6;
  localparam int RIDX_W      = 3;
  localparam int SUM_W_DEF   = $clog2(MAX_DIM_DEF * MAX_DIM_DEF * 255 + 1);

  localparam logic [SUIT_W-1:0] SUIT_NONE     = 3'd0;
  localparam logic [SUIT_W-1:0] SUIT_HEARTS   = 3'd1;
  localparam logic [SUIT_W-1:0] SUIT_DIAMONDS = 3'd2;
  localparam logic [SUIT_W-1:0] SUIT_SPADES   = 3'd3;
  localparam logic [SUIT_W-1:0] SUIT_CLUBS    = 3'd4;

  localparam logic [ZONE_W-1:0] ZONE_TL  = 4'd0;
  localparam logic [ZONE_W-1:0] ZONE_T1  = 4'd1;
  localparam logic [ZONE_W-1:0] ZONE_T2  = 4'd2;
  localparam logic [ZONE_W-1:0] ZONE_TR  = 4'd3;
  localparam logic [ZONE_W-1:0] ZONE_BL  = 4'd12;
  localparam logic [ZONE_W-1:0] ZONE_BR  = 4'd15;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              clr_en;
    logic              clr_bank;
  } zdsc_mem_ctl_t;

  // Zones that the rule trees look at, in the order the classifier reads them.
  function automatic logic [ZONE_W-1:0] zone_of(input logic [RIDX_W-1:0] idx);
    logic [ZONE_W-1:0] z;
    unique case (idx)
      3'd0:    z = ZONE_TL;
      3'd1:    z = ZONE_T1;
      3'd2:    z = ZONE_T2;
      3'd3:    z = ZONE_TR;
      3'd4:    z = ZONE_BL;
      3'd5:    z = ZONE_BR;
      default: z = ZONE_TL;
    endcase
    return z;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/zone_density_suit_classifier_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Zone-density suit classifier. Pixels of a symbol image enter in raster order at one
// beat per cycle unless in_stall holds one off, each with the symbol's width and
// height; every pixel inside the four-by-four zone grid is added into one of sixteen
// zone sums held in a two-bank memory, read one cycle and written back the next, with
// forwarding between neighbouring pixels of the same zone. Successive symbols
// alternate banks, so a symbol may start in the cycle after the previous one ended.
// After the last pixel a sequencer reads the six zones that the rules need through
// the memory's second read port, forms the dark fractions, evaluates the rule tree
// and emits the suit beat. The last pixel of a symbol is held off while the previous
// symbol is still being classified, so symbols stream at one pixel per cycle unless
// one ends before the previous one's classification is done. A stalled result beat
// holds the sequencer in its last step and so holds the next symbol end off longer.
// A symbol that matches no rule in the normal tree gives no result. blurred_mode
// selects the fallback tree; the user writes it while the block is idle; not enforced.

module zone_density_suit_classifier_top #(
  parameter int MAX_DIM = zdsc_pkg::MAX_DIM_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          blurred_mode,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [zdsc_pkg::PIX_W-1:0]    pixel,
  input  wire logic [zdsc_pkg::DIM_IN_W-1:0] width,
  input  wire logic [zdsc_pkg::DIM_IN_W-1:0] height,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [zdsc_pkg::SUIT_W-1:0]   suit
);
  import zdsc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CELL_W = $clog2(MAX_DIM / 4 + 1);
  localparam int SUM_W  = $clog2(MAX_DIM * MAX_DIM * 255 + 1);
  localparam int PROD_W = CELL_W + DIM_W;
  localparam int AREA_W = PROD_W - 2;
  localparam int K_W    = AREA_W + 8;
  localparam int CMP_W  = ((K_W > SUM_W) ? K_W : SUM_W) + 10;
  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_AREA  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_K     = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DIFF  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_SCALE = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd9;

  localparam logic signed [CMP_W-1:0] C10  = CMP_W'(10);
  localparam logic signed [CMP_W-1:0] C12  = CMP_W'(12);
  localparam logic signed [CMP_W-1:0] C16  = CMP_W'(16);
  localparam logic signed [CMP_W-1:0] C40  = CMP_W'(40);
  localparam logic signed [CMP_W-1:0] C100 = CMP_W'(100);
  localparam logic signed [CMP_W-1:0] C110 = CMP_W'(110);
  localparam logic signed [CMP_W-1:0] C140 = CMP_W'(140);

  // Configuration.
  logic blurred;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blurred <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      blurred <= blurred_mode;
    end
  end

  // Position tracking and zone selection.
  logic [CNT_W-1:0]  col_count, row_count;
  logic              bank;
  logic [DIM_W-1:0]  w_c, h_c;
  logic [CELL_W-1:0] cw, rh;
  logic [DIM_W-1:0]  ccx, rcx;
  logic [1:0]        zx, zy;
  logic              in_range, pos_first, last_col, pos_last, in_acc;
  logic [ADDR_W-1:0] in_addr;

  always_comb begin
    if (width == '0) begin
      w_c = DIM_W'(1);
    end else if (32'(width) > 32'(MAX_DIM)) begin
      w_c = DIM_W'(MAX_DIM);
    end else begin
      w_c = DIM_W'(width);
    end
    if (height == '0) begin
      h_c = DIM_W'(1);
    end else if (32'(height) > 32'(MAX_DIM)) begin
      h_c = DIM_W'(MAX_DIM);
    end else begin
      h_c = DIM_W'(height);
    end
    cw  = CELL_W'(w_c >> 2);
    rh  = CELL_W'(h_c >> 2);
    ccx = DIM_W'(col_count);
    rcx = DIM_W'(row_count);

    if (ccx >= DIM_W'(cw) + DIM_W'(cw) + DIM_W'(cw)) begin
      zx = 2'd3;
    end else if (ccx >= DIM_W'(cw) + DIM_W'(cw)) begin
      zx = 2'd2;
    end else if (ccx >= DIM_W'(cw)) begin
      zx = 2'd1;
    end else begin
      zx = 2'd0;
    end
    if (rcx >= DIM_W'(rh) + DIM_W'(rh) + DIM_W'(rh)) begin
      zy = 2'd3;
    end else if (rcx >= DIM_W'(rh) + DIM_W'(rh)) begin
      zy = 2'd2;
    end else if (rcx >= DIM_W'(rh)) begin
      zy = 2'd1;
    end else begin
      zy = 2'd0;
    end

    in_range  = (cw != '0) && (rh != '0) && (ccx < {cw, 2'b00}) && (rcx < {rh, 2'b00});
    pos_first = (col_count == '0) && (row_count == '0);
    last_col  = (ccx + DIM_W'(1)) >= w_c;
    pos_last  = last_col && ((rcx + DIM_W'(1)) >= h_c);
    in_addr   = {bank, zy, zx};
  end

  // Classifier state, declared early for the input interlock.
  logic              cls_busy;
  logic [STEP_W-1:0] cls_cnt;
  logic              s1_valid, s1_last;

  assign in_stall = pos_last && (cls_busy || (s1_valid && s1_last));
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      bank      <= 1'b0;
    end else if (in_acc) begin
      if (last_col) begin
        col_count <= '0;
        if (pos_last) begin
          row_count <= '0;
          bank      <= ~bank;
        end else begin
          row_count <= row_count + CNT_W'(1);
        end
      end else begin
        col_count <= col_count + CNT_W'(1);
      end
    end
  end

  // Accumulate stage: memory data arrives, sum is written back.
  logic [PIX_W-1:0]  s1_px;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_wr, s1_first, s1_bank;
  logic [DIM_W-1:0]  s1_w, s1_h;
  logic              fwd_hit;
  logic [SUM_W-1:0]  fwd_data;
  logic [SUM_W-1:0]  s1_sum;
  logic [SUM_W-1:0]  rd_a_data, rd_b_data;
  logic              rd_a_valid, rd_b_valid;
  logic [ADDR_W-1:0] rd_b_addr;
  zdsc_mem_ctl_t     mem_ctl;

  always_comb begin
    if (fwd_hit) begin
      s1_sum = fwd_data + SUM_W'(s1_px);
    end else if (rd_a_valid && !s1_first) begin
      s1_sum = rd_a_data + SUM_W'(s1_px);
    end else begin
      s1_sum = SUM_W'(s1_px);
    end
    mem_ctl.wr_en    = s1_valid && s1_wr;
    mem_ctl.wr_addr  = s1_addr;
    mem_ctl.clr_en   = in_acc && pos_first;
    mem_ctl.clr_bank = bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px    <= pixel;
      s1_addr  <= in_addr;
      s1_wr    <= in_range;
      s1_first <= pos_first;
      s1_last  <= pos_last;
      s1_bank  <= bank;
      s1_w     <= w_c;
      s1_h     <= h_c;
      fwd_hit  <= s1_valid && s1_wr && (s1_addr == in_addr) && !pos_first;
      fwd_data <= s1_sum;
    end
  end

  zdsc_zone_mem #(
    .SUM_W (SUM_W)
  ) u_zone_mem (
    .clk        (clk),
    .rst        (rst),
    .ctl        (mem_ctl),
    .wr_data    (s1_sum),
    .rd_a_addr  (in_addr),
    .rd_a_data  (rd_a_data),
    .rd_a_valid (rd_a_valid),
    .rd_b_addr  (rd_b_addr),
    .rd_b_data  (rd_b_data),
    .rd_b_valid (rd_b_valid)
  );

  // Classification sequencer.
  logic                     cls_bank;
  logic [CELL_W-1:0]        cls_cw;
  logic [DIM_W-1:0]         cls_w, cls_h;
  logic [AREA_W-1:0]        cls_area;
  logic [K_W-1:0]           cls_k;
  logic [SUM_W-1:0]         zsum [READS];
  logic signed [CMP_W-1:0]  dz [READS];
  logic signed [CMP_W-1:0]  k_s;
  logic signed [CMP_W-1:0]  p0, p3, p12, p03, p1215, pmid;
  logic signed [CMP_W-1:0]  t10, t12, t16, t40, t100, t110, t140;
  logic                     narrow;
  logic [PROD_W-1:0]        prod;
  logic [SUIT_W-1:0]        suit_sel;
  logic                     emit_go;

  assign rd_b_addr = {cls_bank, zone_of(cls_cnt[RIDX_W-1:0])};
  assign prod      = PROD_W'(cls_cw) * PROD_W'(cls_h);
  assign k_s       = signed'(CMP_W'(cls_k));
  assign emit_go   = !(out_valid && out_stall);

  always_comb begin
    if (blurred) begin
      if (narrow) begin
        suit_sel = SUIT_DIAMONDS;
      end else if (p03 > t100) begin
        suit_sel = SUIT_HEARTS;
      end else if (pmid > t140) begin
        suit_sel = SUIT_CLUBS;
      end else begin
        suit_sel = SUIT_SPADES;
      end
    end else begin
      if (p0 > t40 && p3 > t40) begin
        suit_sel = SUIT_HEARTS;
      end else if (pmid > t110 && p0 < t10 && p12 > t10) begin
        suit_sel = SUIT_CLUBS;
      end else if (p03 < t12 && p1215 < t16) begin
        suit_sel = SUIT_DIAMONDS;
      end else if (pmid < t110) begin
        suit_sel = SUIT_SPADES;
      end else begin
        suit_sel = SUIT_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_busy <= 1'b0;
      cls_cnt  <= STEP_AREA;
    end else if (!cls_busy) begin
      if (s1_valid && s1_last) begin
        cls_busy <= 1'b1;
        cls_cnt  <= STEP_AREA;
      end
    end else if (cls_cnt != STEP_EMIT) begin
      cls_cnt <= cls_cnt + STEP_W'(1);
    end else if (emit_go) begin
      cls_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!cls_busy && s1_valid && s1_last) begin
      cls_bank <= s1_bank;
      cls_w    <= s1_w;
      cls_h    <= s1_h;
      cls_cw   <= CELL_W'(s1_w >> 2);
    end
    if (cls_busy) begin
      if (cls_cnt >= STEP_W'(1) && cls_cnt <= STEP_W'(READS)) begin
        zsum[RIDX_W'(cls_cnt - STEP_W'(1))] <= rd_b_valid ? rd_b_data : '0;
      end
      unique case (cls_cnt)
        STEP_AREA: begin
          cls_area <= prod[PROD_W-1:2];
        end
        STEP_K: begin
          cls_k <= {cls_area, 8'b0} - K_W'(cls_area);
        end
        STEP_DIFF: begin
          for (int i = 0; i < READS; i++) begin
            dz[i] <= k_s - signed'(CMP_W'(zsum[i]));
          end
        end
        STEP_SCALE: begin
          p0     <= dz[0] * C100;
          p3     <= dz[3] * C100;
          p12    <= dz[4] * C100;
          p03    <= (dz[0] + dz[3]) * C100;
          p1215  <= (dz[4] + dz[5]) * C100;
          pmid   <= (dz[1] + dz[2]) * C100;
          t10    <= k_s * C10;
          t12    <= k_s * C12;
          t16    <= k_s * C16;
          t40    <= k_s * C40;
          t100   <= k_s * C100;
          t110   <= k_s * C110;
          t140   <= k_s * C140;
          narrow <= ({1'b0, cls_w, 1'b0}) < ({1'b0, cls_h, 1'b0} + {2'b00, cls_h});
        end
        default: begin
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cls_busy && cls_cnt == STEP_EMIT && emit_go && suit_sel != SUIT_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cls_busy && cls_cnt == STEP_EMIT && emit_go) begin
      suit <= suit_sel;
    end
  end

  // A symbol end is never taken while the previous symbol is still being classified.
  a_end_interlock: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && pos_last |-> !cls_busy)
    else $error("symbol end accepted during classification");

  a_suit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (suit != SUIT_NONE) && (suit <= SUIT_CLUBS))
    else $error("result beat without a suit");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    cls_busy |-> cls_cnt <= STEP_EMIT)
    else $error("classifier step out of range");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last |-> !cls_busy)
    else $error("classification started while busy");

endmodule

`default_nettype wire

/* hw/rtl/zdsc_zone_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module zdsc_zone_mem #(
  parameter int SUM_W = zdsc_pkg::SUM_W_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire zdsc_pkg::zdsc_mem_ctl_t     ctl,
  input  wire logic [SUM_W-1:0]            wr_data,
  input  wire logic [zdsc_pkg::ADDR_W-1:0] rd_a_addr,
  output logic      [SUM_W-1:0]            rd_a_data,
  output logic                             rd_a_valid,
  input  wire logic [zdsc_pkg::ADDR_W-1:0] rd_b_addr,
  output logic      [SUM_W-1:0]            rd_b_data,
  output logic                             rd_b_valid
);
  import zdsc_pkg::*;

  localparam int ENTRIES = 2 * ZONES;

  logic [SUM_W-1:0]   mem [ENTRIES];
  logic [ENTRIES-1:0] vld;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    rd_a_data  <= mem[rd_a_addr];
    rd_b_data  <= mem[rd_b_addr];
    rd_a_valid <= vld[rd_a_addr];
    rd_b_valid <= vld[rd_b_addr];
  end

  // An entry that has not been written since its bank was cleared reads with its valid flag low.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ctl.clr_en) begin
        for (int i = 0; i < ZONES; i++) begin
          vld[{ctl.clr_bank, ZONE_W'(i)}] <= 1'b0;
        end
      end
      if (ctl.wr_en) begin
        vld[ctl.wr_addr] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* test/tb_zone_density_suit_classifier_top.sv */
`timescale 1ns / 1ps

module tb_zone_density_suit_classifier_top;
  import zdsc_pkg::*;

  localparam int CYCLE_LIMIT = 1200000;
  localparam int NO_SWITCH   = 1 << 30;
  localparam int RANDOM_ITEMS = 500;

  typedef struct packed {
    logic [PIX_W-1:0]    px;
    logic [DIM_IN_W-1:0] w;
    logic [DIM_IN_W-1:0] h;
  } pixel_beat_t;

  typedef logic [PIX_W-1:0] zone_levels_t [ZONES];

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                blurred_mode = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PIX_W-1:0]    pixel = '0;
  logic [DIM_IN_W-1:0] width = '0;
  logic [DIM_IN_W-1:0] height = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SUIT_W-1:0]   suit;

  pixel_beat_t       pending_pixels[$];
  logic [SUIT_W-1:0] suit_expected[$];

  int unsigned zone_sum [ZONES];
  int unsigned pos_col = 0;
  int unsigned pos_row = 0;
  bit          blurred_now = 1'b0;

  int unsigned gen_col = 0;
  int unsigned gen_row = 0;
  int          queued_count = 0;

  int gap_left = 0;
  int in_calm = 0;
  int hold_left = 0;
  int out_calm = 0;
  int cycle_count = 0;
  int mismatch_count = 0;

  zone_density_suit_classifier_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .blurred_mode (blurred_mode),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel        (pixel),
    .width        (width),
    .height       (height),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .suit         (suit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned dim_of(logic [DIM_IN_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(v);
  endfunction

  function automatic logic [SUIT_W-1:0] suit_of_zones(int unsigned w, int unsigned h);
    longint k, d_tl, d_t1, d_t2, d_tr, d_bl, d_br;
    k    = 255 * longint'(((w / 4) * h) / 4);
    d_tl = 100 * (k - longint'(zone_sum[ZONE_TL]));
    d_t1 = 100 * (k - longint'(zone_sum[ZONE_T1]));
    d_t2 = 100 * (k - longint'(zone_sum[ZONE_T2]));
    d_tr = 100 * (k - longint'(zone_sum[ZONE_TR]));
    d_bl = 100 * (k - longint'(zone_sum[ZONE_BL]));
    d_br = 100 * (k - longint'(zone_sum[ZONE_BR]));
    if (blurred_now) begin
      if (2 * w < 3 * h) return SUIT_DIAMONDS;
      if (d_tl + d_tr > 100 * k) return SUIT_HEARTS;
      if (d_t1 + d_t2 > 140 * k) return SUIT_CLUBS;
      return SUIT_SPADES;
    end
    if (d_tl > 40 * k && d_tr > 40 * k) return SUIT_HEARTS;
    if (d_t1 + d_t2 > 110 * k && d_tl < 10 * k && d_bl > 10 * k) return SUIT_CLUBS;
    if (d_tl + d_tr < 12 * k && d_bl + d_br < 16 * k) return SUIT_DIAMONDS;
    if (d_t1 + d_t2 < 110 * k) return SUIT_SPADES;
    return SUIT_NONE;
  endfunction

  task automatic take_pixel(pixel_beat_t b);
    int unsigned w, h, cw, rh;
    logic [SUIT_W-1:0] s;
    w  = dim_of(b.w);
    h  = dim_of(b.h);
    cw = w / 4;
    rh = h / 4;
    if (pos_col == 0 && pos_row == 0) begin
      foreach (zone_sum[i]) zone_sum[i] = 0;
    end
    if (cw != 0 && rh != 0 && pos_col < 4 * cw && pos_row < 4 * rh) begin
      zone_sum[(pos_row / rh) * 4 + pos_col / cw] += b.px;
    end
    if (pos_col + 1 >= w) begin
      pos_col = 0;
      if (pos_row + 1 >= h) begin
        pos_row = 0;
        s = suit_of_zones(w, h);
        if (s != SUIT_NONE) suit_expected = {suit_expected, s};
      end else begin
        pos_row++;
      end
    end else begin
      pos_col++;
    end
  endtask

  function automatic zone_levels_t shade(logic [ZONES-1:0] dark);
    zone_levels_t lvl;
    foreach (lvl[i]) lvl[i] = dark[i] ? 8'd0 : 8'd255;
    return lvl;
  endfunction

  // Queues whole symbols: pixels are generated until the position returns to the
  // top-left corner, so the dimensions may change part-way through.
  task automatic queue_symbol(logic [DIM_IN_W-1:0] w_a, logic [DIM_IN_W-1:0] h_a,
                              logic [DIM_IN_W-1:0] w_b, logic [DIM_IN_W-1:0] h_b,
                              int switch_at, zone_levels_t lvl, int noise_pct);
    pixel_beat_t b;
    int n;
    int unsigned w, h, cw, rh;
    n = 0;
    do begin
      b.w = (n < switch_at) ? w_a : w_b;
      b.h = (n < switch_at) ? h_a : h_b;
      w   = dim_of(b.w);
      h   = dim_of(b.h);
      cw  = w / 4;
      rh  = h / 4;
      if (cw != 0 && rh != 0 && gen_col < 4 * cw && gen_row < 4 * rh) begin
        b.px = lvl[(gen_row / rh) * 4 + gen_col / cw];
      end else begin
        b.px = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 99) < noise_pct) b.px = 8'($urandom_range(0, 255));
      pending_pixels = {pending_pixels, b};
      n++;
      if (gen_col + 1 >= w) begin
        gen_col = 0;
        if (gen_row + 1 >= h) gen_row = 0;
        else gen_row++;
      end else begin
        gen_col++;
      end
    end while (gen_col != 0 || gen_row != 0);
    queued_count += n;
  endtask

  task automatic queue_random_symbols(int n_items);
    int start, sw;
    logic [DIM_IN_W-1:0] wa, ha, wb, hb, tmp;
    zone_levels_t lvl;
    start = queued_count;
    while (queued_count - start < n_items) begin
      if ($urandom_range(0, 99) < 4) begin
        wa = 9'($urandom_range(0, 511));
        ha = 9'($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 1) begin
          tmp = wa;
          wa  = ha;
          ha  = tmp;
        end
      end else begin
        wa = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 10)) : 9'($urandom_range(4, 10));
        ha = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 10)) : 9'($urandom_range(4, 10));
      end
      wb = wa;
      hb = ha;
      sw = NO_SWITCH;
      if ($urandom_range(0, 99) < 8) begin
        wb = 9'($urandom_range(0, 12));
        hb = 9'($urandom_range(0, 12));
        sw = int'($urandom_range(0, dim_of(wa) * dim_of(ha)));
      end
      foreach (lvl[i]) begin
        case ($urandom_range(0, 3))
          0:       lvl[i] = 8'd0;
          1:       lvl[i] = 8'd255;
          default: lvl[i] = 8'($urandom_range(0, 255));
        endcase
      end
      queue_symbol(wa, ha, wb, hb, sw, lvl, int'($urandom_range(0, 30)));
    end
  endtask

  task automatic write_mode(bit v);
    @(posedge clk);
    blurred_mode <= v;
    cfg_valid    <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    blurred_now  = v;
  endtask

  task automatic settle_block();
    int waited;
    do @(posedge clk); while (pending_pixels.size() != 0 || in_valid);
    waited = 0;
    while (suit_expected.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (suit_expected.size() != 0) begin
      flag_mismatch($sformatf("%0d suit beats never arrived", suit_expected.size()));
      suit_expected.delete();
    end
  endtask

  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  always @(posedge clk) begin : drive_pixels
    pixel_beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left  = 0;
    end else begin
      if (in_valid && !in_stall) begin
        b.px = pixel;
        b.w  = width;
        b.h  = height;
        take_pixel(b);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          b = pending_pixels.pop_front();
          pixel    <= b.px;
          width    <= b.w;
          height   <= b.h;
          in_valid <= 1'b1;
          if (in_calm > 0) in_calm--;
          else if ($urandom_range(0, 149) == 0) in_calm = int'($urandom_range(40, 160));
          gap_left = idle_len(in_calm > 0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_suits
    logic [SUIT_W-1:0] want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (suit_expected.size() == 0) begin
          flag_mismatch($sformatf("suit beat %0d with nothing expected", suit));
        end else begin
          want = suit_expected.pop_front();
          if (suit !== want) flag_mismatch($sformatf("suit %0d, expected %0d", suit, want));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_calm > 0) out_calm--;
        else if ($urandom_range(0, 149) == 0) out_calm = int'($urandom_range(40, 160));
        hold_left = idle_len(out_calm > 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    foreach (zone_sum[i]) zone_sum[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_mode(1'b0);
    queue_symbol(9'd0, 9'd0, 9'd0, 9'd0, NO_SWITCH, shade(16'hffff), 0);
    queue_symbol(9'd4, 9'd4, 9'd4, 9'd4, NO_SWITCH, shade(16'hffff), 0);
    queue_symbol(9'd4, 9'd4, 9'd4, 9'd4, NO_SWITCH, shade(16'h0000), 0);
    queue_symbol(9'd8, 9'd8, 9'd8, 9'd8, NO_SWITCH, shade(16'h1006), 0);
    queue_symbol(9'd8, 9'd8, 9'd8, 9'd8, NO_SWITCH, shade(16'h0001), 0);
    queue_symbol(9'd8, 9'd8, 9'd8, 9'd8, NO_SWITCH, shade(16'h0007), 0);
    queue_symbol(9'd7, 9'd6, 9'd7, 9'd6, NO_SWITCH, shade(16'($urandom)), 30);
    queue_symbol(9'd511, 9'd1, 9'd511, 9'd1, NO_SWITCH, shade(16'h0000), 50);
    queue_symbol(9'd1, 9'd300, 9'd1, 9'd300, NO_SWITCH, shade(16'h0000), 50);
    queue_symbol(9'd64, 9'd4, 9'd64, 9'd4, NO_SWITCH, shade(16'h9009), 10);
    queue_symbol(9'd8, 9'd8, 9'd5, 9'd3, 20, shade(16'hffff), 0);
    queue_symbol(9'd12, 9'd9, 9'd12, 9'd9, NO_SWITCH, shade(16'($urandom)), 0);
    settle_block();

    write_mode(1'b1);
    queue_symbol(9'd4, 9'd4, 9'd4, 9'd4, NO_SWITCH, shade(16'h0000), 0);
    queue_symbol(9'd8, 9'd4, 9'd8, 9'd4, NO_SWITCH, shade(16'hffff), 0);
    queue_symbol(9'd8, 9'd4, 9'd8, 9'd4, NO_SWITCH, shade(16'h0006), 0);
    queue_symbol(9'd8, 9'd4, 9'd8, 9'd4, NO_SWITCH, shade(16'h0000), 0);
    queue_symbol(9'd6, 9'd4, 9'd6, 9'd4, NO_SWITCH, shade(16'hffff), 0);
    queue_symbol(9'd3, 9'd1, 9'd3, 9'd1, NO_SWITCH, shade(16'hffff), 0);
    queue_symbol(9'd0, 9'd1, 9'd0, 9'd1, NO_SWITCH, shade(16'hffff), 0);
    queue_symbol(9'd9, 9'd6, 9'd9, 9'd6, NO_SWITCH, shade(16'($urandom)), 10);
    settle_block();

    for (int phase = 0; phase < 4; phase++) begin
      write_mode(phase[0]);
      queue_random_symbols(RANDOM_ITEMS / 4);
      settle_block();
    end

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/zdsc_pkg.sv
hw/rtl/zdsc_zone_mem.sv
hw/rtl/zone_density_suit_classifier_top.sv
test/tb_zone_density_suit_classifier_top.sv
